// ===== rtl/core/bmm_pkg.sv =====
`default_nettype none

package bmm_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_MEM_RD = 2'd0;
  localparam logic [1:0] KIND_MEM_WR = 2'd1;
  localparam logic [1:0] KIND_IO_WR  = 2'd2;
  localparam logic [1:0] KIND_NMI    = 2'd3;

  // Result targets.
  localparam logic [1:0] TGT_ROM  = 2'd0;
  localparam logic [1:0] TGT_RAM  = 2'd1;
  localparam logic [1:0] TGT_NONE = 2'd2;

  // 16 KiB windows of the CPU address space.
  localparam logic [1:0] WIN_ROM  = 2'd0;
  localparam logic [1:0] WIN_MID1 = 2'd1;
  localparam logic [1:0] WIN_MID2 = 2'd2;
  localparam logic [1:0] WIN_TOP  = 2'd3;

  localparam logic [5:0] BANK_MID1     = 6'd5;
  localparam logic [5:0] BANK_MID2     = 6'd2;
  localparam logic [5:0] BANK_ROM_DEF  = 6'd3;
  localparam logic [5:0] BANK_RAM_LOW  = 6'd0;
  localparam logic [5:0] BANK_RAM_HIGH = 6'd8;

  localparam logic [7:0]  SYS_PORT_LOW    = 8'h00;
  localparam logic [7:0]  TOP_DIRECT_MASK = 8'b0010_0111;
  localparam logic [7:0]  TOP_SHIFT_MASK  = 8'b0001_1000;
  localparam logic [7:0]  RAM_SEL_MASK    = 8'b0000_1001;
  localparam logic [15:0] PAGE_DECODE     = 16'h8002;
  localparam logic [3:0]  FLOPPY_NIBBLE   = 4'h8;

  typedef struct packed {
    logic [7:0] sys_port;
    logic [7:0] page_port;
  } bmm_state_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [5:0]  bank;
    logic [13:0] offset;
    logic        write_enable;
    logic [7:0]  write_data;
    logic        alt_screen;
  } bmm_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bmm_xlate.sv =====
`default_nettype none

module bmm_xlate
  import bmm_pkg::*;
(
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  input  wire logic        dos_active,
  input  wire bmm_state_t  state_cur,
  output bmm_state_t       state_nxt,
  output bmm_result_t      result
);

  logic [7:0] low;
  logic       floppy_hit;
  logic       page_hit;
  logic [7:0] top_wide;
  logic [7:0] ram_sel;

  assign low      = address[7:0];
  assign ram_sel  = state_cur.sys_port & RAM_SEL_MASK;
  assign top_wide = (state_cur.page_port & TOP_DIRECT_MASK)
                  | ((state_cur.page_port >> 3) & TOP_SHIFT_MASK);
  assign page_hit = address[0] && ((~address & PAGE_DECODE) == PAGE_DECODE);

  always_comb begin
    floppy_hit = 1'b0;
    if (low[7:4] == FLOPPY_NIBBLE && !state_cur.sys_port[7]) begin
      floppy_hit = low inside {[8'h80:8'h83], 8'h85};
    end
  end

  always_comb begin
    state_nxt = state_cur;
    result    = '0;
    result.target = TGT_NONE;

    case (kind)
      KIND_IO_WR: begin
        if (low == SYS_PORT_LOW) begin
          state_nxt.sys_port = data;
        end else if (!dos_active && !floppy_hit && page_hit) begin
          state_nxt.page_port = data;
        end
      end
      KIND_NMI: begin
        state_nxt.sys_port = '0;
      end
      default: begin
        case (address[15:14])
          WIN_ROM: begin
            if (ram_sel == 8'h01) begin
              result.target = TGT_RAM;
              result.bank   = BANK_RAM_LOW;
            end else if (ram_sel == RAM_SEL_MASK) begin
              result.target = TGT_RAM;
              result.bank   = BANK_RAM_HIGH;
            end else begin
              result.target = TGT_ROM;
              if (!state_cur.sys_port[5]) begin
                result.bank = BANK_ROM_DEF;
              end else begin
                result.bank = {5'd0, state_cur.page_port[4]};
              end
            end
          end
          WIN_MID1: begin
            result.target = TGT_RAM;
            result.bank   = BANK_MID1;
          end
          WIN_MID2: begin
            result.target = TGT_RAM;
            result.bank   = BANK_MID2;
          end
          default: begin
            result.target = TGT_RAM;
            result.bank   = top_wide[5:0];
          end
        endcase
        result.offset = address[13:0];

        // A write into ROM is dropped and reported as no access.
        if (kind == KIND_MEM_WR) begin
          if (result.target == TGT_RAM) begin
            result.write_enable = 1'b1;
            result.write_data   = data;
          end else begin
            result.target = TGT_NONE;
            result.bank   = '0;
            result.offset = '0;
          end
        end
      end
    endcase

    result.alt_screen = state_nxt.page_port[3];
  end

endmodule

`default_nettype wire

// ===== rtl/core/banked_memory_mapper.sv =====
`default_nettype none

// Banked memory mapper: translates each CPU request into a ROM or RAM bank and
// a 14-bit offset, and tracks the system port and the 7FFD-style paging port.
// Input channel: in_valid / in_stall with kind, address, data and dos_active.
// A memory read or write yields a translation; an io write may load one of the
// two paging registers; an nmi request clears the system port. Every request
// produces exactly one result on the output channel (out_valid / out_stall).
// A request taken from the input channel sits in the input register, moves
// to the result register when that register is free, and leaves from there
// once the receiver does not stall. The translation logic sits between the two
// registers. Throughput is one request per cycle while out_stall is low; the
// paging registers are updated as a request leaves the input register, so the
// next request already sees the new mapping.
// When the receiver asserts out_stall the result register holds its request,
// the input register can still take one more request, and only then does
// in_stall rise. A synchronous active-low reset clears both paging registers
// and empties both pipeline stages; no clearing pass is needed.
module banked_memory_mapper
  import bmm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_data,
  input  wire logic        in_dos_active,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_target,
  output logic [5:0]       out_bank,
  output logic [13:0]      out_offset,
  output logic             out_write_enable,
  output logic [7:0]       out_write_data,
  output logic             out_alt_screen
);

  // Input register stage.
  logic        s1_valid_r;
  logic [1:0]  s1_kind_r;
  logic [15:0] s1_address_r;
  logic [7:0]  s1_data_r;
  logic        s1_dos_r;

  // Paging state and result register.
  bmm_state_t  state_r;
  bmm_state_t  state_nxt;
  bmm_result_t result_nxt;
  bmm_result_t out_r;
  logic        out_valid_r;

  logic s2_ready;
  logic s1_ready;
  logic s1_move;

  // The result register takes a new request when empty or being drained.
  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && s2_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_kind_r    <= in_kind;
      s1_address_r <= in_address;
      s1_data_r    <= in_data;
      s1_dos_r     <= in_dos_active;
    end
  end

  bmm_xlate u_xlate (
    .kind       (s1_kind_r),
    .address    (s1_address_r),
    .data       (s1_data_r),
    .dos_active (s1_dos_r),
    .state_cur  (state_r),
    .state_nxt  (state_nxt),
    .result     (result_nxt)
  );

  // The paging registers commit only when the request moves on, so a stalled
  // request is never applied twice.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_move) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target       = out_r.target;
  assign out_bank         = out_r.bank;
  assign out_offset       = out_r.offset;
  assign out_write_enable = out_r.write_enable;
  assign out_write_data   = out_r.write_data;
  assign out_alt_screen   = out_r.alt_screen;

  // A request with no memory access carries no bank, offset or write.
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.target == TGT_NONE
      |-> out_r.bank == 6'd0 && out_r.offset == 14'd0 && !out_r.write_enable)
    else $error("non-memory result carries bank, offset or write");

  // Only RAM is ever written.
  a_write_ram: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.write_enable |-> out_r.target == TGT_RAM)
    else $error("write enabled on a non-RAM target");

  // ROM bank numbers stay within the four ROM pages.
  a_rom_bank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.target == TGT_ROM |-> out_r.bank[5:2] == 4'd0)
    else $error("ROM bank out of range");

  // An nmi request clears the system port as it leaves the input register.
  a_nmi_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && s1_kind_r == KIND_NMI |=> state_r.sys_port == 8'd0)
    else $error("system port not cleared by nmi");

  // The input side only stalls with a full input register.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
